>>> rtl/xor_checked_telemetry_line_parser_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the telemetry line parser
// Clocked, reset-gated concurrent assertion wrappers.
// ----------------------------------------------------------------------------
`ifndef XOR_CHECKED_TELEMETRY_LINE_PARSER_UNIT_MACROS_SVH
`define XOR_CHECKED_TELEMETRY_LINE_PARSER_UNIT_MACROS_SVH

// same-cycle implication
`define XCTLP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define XCTLP_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/xctlp_pkg.sv
// ----------------------------------------------------------------------------
// xctlp_pkg
// Shared types and constants of the telemetry line parser.
// ----------------------------------------------------------------------------
package xctlp_pkg;

	localparam int LINE_LIMIT = 128;
	localparam int CNT_W      = 8;
	localparam int NUM_FIELDS = 10;
	localparam int NUM_OUTV   = NUM_FIELDS - 1;
	localparam int CC_W       = 4;
	localparam int FIDX_W     = $clog2(NUM_FIELDS);
	localparam int STAR_LAST  = LINE_LIMIT - 7;
	localparam int XOR_LAST   = LINE_LIMIT - 8;
	localparam int SHORT_LAST = 3;
	localparam int COMMA_MAX  = NUM_FIELDS + 1;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UF    = 8'h46;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LF    = 8'h66;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_SHORT = 2'd1;
	localparam logic [1:0] ST_CSUM  = 2'd2;

	typedef enum logic [3:0] {
		PH_SPACE  = 4'b0001,
		PH_SIGN   = 4'b0010,
		PH_DIGITS = 4'b0100,
		PH_DONE   = 4'b1000
	} phase_t;

	// classified byte handed from front to back
	typedef struct packed {
		logic [7:0] data;
		logic       is_nl;
		logic       is_comma;
		logic       is_star;
		logic       is_hash;
		logic       is_space;
		logic       is_plus;
		logic       is_minus;
		logic       is_digit;
		logic       hex_ok;
		logic [3:0] hex_val;
	} tok_t;

	typedef struct packed {
		logic [NUM_OUTV-1:0][15:0] vals;
		logic                      stop;
		logic [1:0]                status;
	} result_t;

endpackage

>>> rtl/xctlp_front.sv
// ----------------------------------------------------------------------------
// xctlp_front
// Accepts received bytes, classifies them and queues the tokens.
// ----------------------------------------------------------------------------
module xctlp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [7:0]        rx_byte,
	output logic              full,
	input  logic              tok_pop,
	output logic              tok_valid,
	output xctlp_pkg::tok_t   tok
);

	xctlp_pkg::tok_t cls;
	xctlp_pkg::tok_t mem_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            do_push;
	logic            do_pop;
	logic            is_dec;
	logic            is_uhex;
	logic            is_lhex;

	always_comb begin
		is_dec  = (rx_byte >= xctlp_pkg::CH_0) && (rx_byte <= xctlp_pkg::CH_9);
		is_uhex = (rx_byte >= xctlp_pkg::CH_UA) && (rx_byte <= xctlp_pkg::CH_UF);
		is_lhex = (rx_byte >= xctlp_pkg::CH_LA) && (rx_byte <= xctlp_pkg::CH_LF);
		cls.data     = rx_byte;
		cls.is_nl    = (rx_byte == xctlp_pkg::CH_NL);
		cls.is_comma = (rx_byte == xctlp_pkg::CH_COMMA);
		cls.is_star  = (rx_byte == xctlp_pkg::CH_STAR);
		cls.is_hash  = (rx_byte == xctlp_pkg::CH_HASH);
		cls.is_space = (rx_byte == xctlp_pkg::CH_SPACE) ||
			((rx_byte >= xctlp_pkg::CH_TAB) && (rx_byte <= xctlp_pkg::CH_CR));
		cls.is_plus  = (rx_byte == xctlp_pkg::CH_PLUS);
		cls.is_minus = (rx_byte == xctlp_pkg::CH_MINUS);
		cls.is_digit = is_dec;
		cls.hex_ok   = is_dec || is_uhex || is_lhex;
		// letters: low nibble 1..6 maps to 10..15
		cls.hex_val  = is_dec ? rx_byte[3:0] : rx_byte[3:0] + 4'd9;
	end

	assign full      = (cnt_q == 2'd2);
	assign tok_valid = (cnt_q != 2'd0);
	assign tok       = mem_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = tok_pop && tok_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= cls;
	end

endmodule

>>> rtl/xctlp_back.sv
// ----------------------------------------------------------------------------
// xctlp_back
// Line state: checksum, hex check digits, field accumulation, commit.
// ----------------------------------------------------------------------------
module xctlp_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 tok_valid,
	input  xctlp_pkg::tok_t      tok,
	input  logic                 out_full,
	output logic                 tok_pop,
	output logic                 res_push,
	output xctlp_pkg::result_t   res
);

	localparam int CW = xctlp_pkg::CNT_W;
	localparam int QW = xctlp_pkg::CC_W;
	localparam int NF = xctlp_pkg::NUM_FIELDS;

	logic [CW-1:0]     cnt_q, cnt_d;
	logic [7:0]        xor_q, xor_d;
	logic              star_q, star_d;
	logic [7:0]        chk_q, chk_d;
	logic              hexd_q, hexd_d;
	logic              cmt_q, cmt_d;
	logic [QW-1:0]     cc_q, cc_d;
	xctlp_pkg::phase_t ph_q, ph_d;
	logic              neg_q, neg_d;
	logic [15:0]       mag_q, mag_d;
	logic [15:0]       pend_q [NF];
	logic [15:0]       pend_d [NF];
	logic [15:0]       held_q [NF];
	logic [15:0]       held_d [NF];

	logic [19:0]       mag_x10;
	logic [15:0]       mag_sat;
	logic [16:0]       neg_ext;
	logic [15:0]       field_val;
	logic [QW-1:0]     fidx_w;
	logic [xctlp_pkg::FIDX_W-1:0] fidx;
	logic              in_field;
	logic              add_dig;
	logic              ok;
	logic              go;
	logic [1:0]        status;

	assign go      = tok_valid && !out_full;
	assign tok_pop = go;

	always_comb begin
		mag_x10 = ({4'd0, mag_q} << 3) + ({4'd0, mag_q} << 1) + {16'd0, tok.data[3:0]};
		mag_sat = (mag_x10 > 20'd32768) ? 16'h8000 : mag_x10[15:0];
		neg_ext = ~{1'b0, mag_sat} + 17'd1;
		field_val = neg_q ? neg_ext[15:0] : (mag_sat[15] ? 16'h7FFF : mag_sat);
		fidx_w  = cc_q - QW'(1);
		fidx    = fidx_w[xctlp_pkg::FIDX_W-1:0];
		in_field = (cc_q >= QW'(1)) && (cc_q <= QW'(NF));

		if (cnt_q <= CW'(xctlp_pkg::SHORT_LAST)) status = xctlp_pkg::ST_SHORT;
		else if (star_q && (xor_q == chk_q))     status = xctlp_pkg::ST_OK;
		else                                     status = xctlp_pkg::ST_CSUM;
		ok = (status == xctlp_pkg::ST_OK);

		for (int k = 0; k < xctlp_pkg::NUM_OUTV; k++)
			res.vals[k] = ok ? pend_q[k] : held_q[k];
		res.stop   = ((ok ? pend_q[NF-1] : held_q[NF-1]) == 16'd1);
		res.status = status;
		res_push   = go && tok.is_nl && !cmt_q;

		cnt_d  = cnt_q;
		xor_d  = xor_q;
		star_d = star_q;
		chk_d  = chk_q;
		hexd_d = hexd_q;
		cmt_d  = cmt_q;
		cc_d   = cc_q;
		ph_d   = ph_q;
		neg_d  = neg_q;
		mag_d  = mag_q;
		pend_d = pend_q;
		held_d = held_q;
		add_dig = 1'b0;

		if (go) begin
			if (tok.is_nl) begin
				if (!cmt_q && ok) held_d = pend_q;
				cnt_d  = '0;
				xor_d  = '0;
				star_d = 1'b0;
				chk_d  = '0;
				hexd_d = 1'b0;
				cmt_d  = 1'b0;
				cc_d   = '0;
				ph_d   = xctlp_pkg::PH_SPACE;
				neg_d  = 1'b0;
				mag_d  = '0;
				for (int k = 0; k < NF; k++) pend_d[k] = '0;
			end else if (cnt_q < CW'(xctlp_pkg::LINE_LIMIT)) begin
				cnt_d = cnt_q + CW'(1);
				if ((cnt_q == '0) && tok.is_hash) cmt_d = 1'b1;
				if (cnt_q != '0) begin
					if (!star_q) begin
						if (tok.is_star && (cnt_q <= CW'(xctlp_pkg::STAR_LAST)))
							star_d = 1'b1;
						else if (cnt_q <= CW'(xctlp_pkg::XOR_LAST))
							xor_d = xor_q ^ tok.data;
					end else if (!hexd_q) begin
						if (tok.hex_ok) chk_d = {chk_q[3:0], tok.hex_val};
						else hexd_d = 1'b1;
					end
				end
				if (tok.is_comma) begin
					if (cc_q < QW'(xctlp_pkg::COMMA_MAX)) cc_d = cc_q + QW'(1);
					ph_d  = xctlp_pkg::PH_SPACE;
					neg_d = 1'b0;
					mag_d = '0;
				end else if (in_field) begin
					case (ph_q)
						xctlp_pkg::PH_SPACE: begin
							if (tok.is_space) begin
								ph_d = xctlp_pkg::PH_SPACE;
							end else if (tok.is_plus) begin
								ph_d = xctlp_pkg::PH_SIGN;
							end else if (tok.is_minus) begin
								ph_d  = xctlp_pkg::PH_SIGN;
								neg_d = 1'b1;
							end else if (tok.is_digit) begin
								ph_d    = xctlp_pkg::PH_DIGITS;
								add_dig = 1'b1;
							end else begin
								ph_d = xctlp_pkg::PH_DONE;
							end
						end
						xctlp_pkg::PH_SIGN, xctlp_pkg::PH_DIGITS: begin
							if (tok.is_digit) begin
								ph_d    = xctlp_pkg::PH_DIGITS;
								add_dig = 1'b1;
							end else begin
								ph_d = xctlp_pkg::PH_DONE;
							end
						end
						default: ph_d = ph_q;
					endcase
					if (add_dig) begin
						mag_d        = mag_sat;
						pend_d[fidx] = field_val;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			xor_q  <= '0;
			star_q <= 1'b0;
			chk_q  <= '0;
			hexd_q <= 1'b0;
			cmt_q  <= 1'b0;
			cc_q   <= '0;
			ph_q   <= xctlp_pkg::PH_SPACE;
			neg_q  <= 1'b0;
			mag_q  <= '0;
			for (int k = 0; k < NF; k++) begin
				pend_q[k] <= '0;
				held_q[k] <= '0;
			end
		end else begin
			cnt_q  <= cnt_d;
			xor_q  <= xor_d;
			star_q <= star_d;
			chk_q  <= chk_d;
			hexd_q <= hexd_d;
			cmt_q  <= cmt_d;
			cc_q   <= cc_d;
			ph_q   <= ph_d;
			neg_q  <= neg_d;
			mag_q  <= mag_d;
			pend_q <= pend_d;
			held_q <= held_d;
		end
	end

endmodule

>>> rtl/xctlp_outq.sv
// ----------------------------------------------------------------------------
// xctlp_outq
// Two-entry result queue between the line logic and the result port.
// ----------------------------------------------------------------------------
module xctlp_outq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 res_push,
	input  xctlp_pkg::result_t   res_in,
	output logic                 out_full,
	input  logic                 pop,
	output logic                 empty,
	output xctlp_pkg::result_t   res_out
);

	xctlp_pkg::result_t mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         cnt_q;
	logic               do_push;
	logic               do_pop;

	assign out_full = (cnt_q == 2'd2);
	assign empty    = (cnt_q == 2'd0);
	assign res_out  = mem_q[rd_ptr_q];
	assign do_push  = res_push && !out_full;
	assign do_pop   = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_pop) rd_ptr_q <= ~rd_ptr_q;
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= res_in;
	end

endmodule

>>> rtl/xor_checked_telemetry_line_parser_unit.sv
// ----------------------------------------------------------------------------
// xor_checked_telemetry_line_parser_unit
// Checksummed telemetry line parser, one received byte per unstalled cycle.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless stalled; each byte takes one step of
//   the line logic (checksum, hex digit shift, decimal accumulate) in the back
//   stage. Path: a newline transfer is written into the token queue; the
//   line logic judges it straight out of that queue and writes the result
//   queue, which drives the ports. A full result queue stalls the back stage.
// Reset: arst_n clears queues, line state and held field values at once.
module xor_checked_telemetry_line_parser_unit (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         rx_byte,
	output logic               empty,
	input  logic               pop,
	output logic signed [15:0] frame_id,
	output logic signed [15:0] panel_volts_tenths,
	output logic signed [15:0] battery_volts_tenths,
	output logic signed [15:0] panel_power,
	output logic signed [15:0] battery_power,
	output logic signed [15:0] electronics_power,
	output logic signed [15:0] left_power,
	output logic signed [15:0] right_power,
	output logic signed [15:0] accessory_power,
	output logic               stop_pressed,
	output logic [1:0]         line_status
);

	xctlp_pkg::tok_t    tok;
	logic               tok_valid;
	logic               tok_pop;
	logic               res_push;
	logic               out_full;
	xctlp_pkg::result_t res_in;
	xctlp_pkg::result_t res_out;

	xctlp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.rx_byte   (rx_byte),
		.full      (full),
		.tok_pop   (tok_pop),
		.tok_valid (tok_valid),
		.tok       (tok)
	);

	xctlp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.tok_valid (tok_valid),
		.tok       (tok),
		.out_full  (out_full),
		.tok_pop   (tok_pop),
		.res_push  (res_push),
		.res       (res_in)
	);

	xctlp_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.res_push (res_push),
		.res_in   (res_in),
		.out_full (out_full),
		.pop      (pop),
		.empty    (empty),
		.res_out  (res_out)
	);

	assign frame_id             = res_out.vals[0];
	assign panel_volts_tenths   = res_out.vals[1];
	assign battery_volts_tenths = res_out.vals[2];
	assign panel_power          = res_out.vals[3];
	assign battery_power        = res_out.vals[4];
	assign electronics_power    = res_out.vals[5];
	assign left_power           = res_out.vals[6];
	assign right_power          = res_out.vals[7];
	assign accessory_power      = res_out.vals[8];
	assign stop_pressed         = res_out.stop;
	assign line_status          = res_out.status;

endmodule

>>> rtl/xctlp_checker.sv
// ----------------------------------------------------------------------------
// xctlp_checker
// Port-level checks of the telemetry line parser, bound to the top level.
// ----------------------------------------------------------------------------
`include "xor_checked_telemetry_line_parser_unit_macros.svh"

module xctlp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [15:0] frame_id,
	input  logic signed [15:0] accessory_power,
	input  logic               stop_pressed,
	input  logic [1:0]         line_status
);

	// a waiting result holds while not taken
	`XCTLP_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(line_status) && $stable(frame_id), "result changed while stalled")

	// only a byte transfer can fill the input queue
	`XCTLP_ASSERT_IMP(a_full_src, clk, arst_n, $rose(full), $past(push), "full rose without push")

	// a rejected line repeats the values of the result before it
	`XCTLP_ASSERT_IMP(a_repeat, clk, arst_n, $past(!empty && pop) && !empty && (line_status != xctlp_pkg::ST_OK), (frame_id == $past(frame_id)) && (accessory_power == $past(accessory_power)) && (stop_pressed == $past(stop_pressed)), "rejected line changed held values")

	`XCTLP_ASSERT_IMP(a_status, clk, arst_n, !empty, line_status <= xctlp_pkg::ST_CSUM, "undefined line status")

endmodule

bind xor_checked_telemetry_line_parser_unit xctlp_checker u_xctlp_checker (.*);

>>> verif/xor_checked_telemetry_line_parser_unit_checker.sv
// ----------------------------------------------------------------------------
// Telemetry line parser scoreboard
// Watches both queue ports of the parser and predicts each line verdict from
// the accepted bytes. Every popped result is compared field by field with the
// oldest predicted verdict. Mismatches are counted for the testbench top.
// ----------------------------------------------------------------------------
module xor_checked_telemetry_line_parser_unit_checker
	import xctlp_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic [7:0]         rx_byte,
	input  logic               empty,
	input  logic               pop,
	input  logic signed [15:0] frame_id,
	input  logic signed [15:0] panel_volts_tenths,
	input  logic signed [15:0] battery_volts_tenths,
	input  logic signed [15:0] panel_power,
	input  logic signed [15:0] battery_power,
	input  logic signed [15:0] electronics_power,
	input  logic signed [15:0] left_power,
	input  logic signed [15:0] right_power,
	input  logic signed [15:0] accessory_power,
	input  logic               stop_pressed,
	input  logic [1:0]         line_status,
	output int                 fails,
	output int                 outstanding
);

	// line state of the predictor
	logic [7:0]  line_len;
	logic [7:0]  csum;
	logic        star_hit;
	logic [7:0]  rx_csum;
	logic        hex_end;
	logic        comment;
	logic [3:0]  commas;
	phase_t      phase;
	logic        neg;
	logic [15:0] mag;
	logic [15:0] pend [NUM_FIELDS];
	logic [15:0] held [NUM_FIELDS];

	result_t     line_verdicts [$];

	task automatic flag(input string msg);
		fails++;
		if (fails <= 10)
			$display("mismatch: %s", msg);
	endtask

	task automatic clear_line();
		line_len = '0;
		csum     = '0;
		star_hit = 1'b0;
		rx_csum  = '0;
		hex_end  = 1'b0;
		comment  = 1'b0;
		commas   = '0;
		phase    = PH_SPACE;
		neg      = 1'b0;
		mag      = '0;
		foreach (pend[k])
			pend[k] = '0;
	endtask

	function automatic int hex_digit_value(input logic [7:0] b);
		if (b >= CH_0 && b <= CH_9)
			return int'(b - CH_0);
		if (b >= CH_UA && b <= CH_UF)
			return int'(b - CH_UA) + 10;
		if (b >= CH_LA && b <= CH_LF)
			return int'(b - CH_LA) + 10;
		return -1;
	endfunction

	task automatic take_digit(input int d);
		int m;
		int v;
		m = int'(mag) * 10 + d;
		if (m > 32768)
			m = 32768;
		mag = m[15:0];
		if (neg)
			v = -m;
		else
			v = (m > 32767) ? 32767 : m;
		pend[commas - 1] = v[15:0];
	endtask

	task automatic field_char(input logic [7:0] b);
		logic digit;
		digit = (b >= CH_0 && b <= CH_9);
		if (commas >= 1 && commas <= NUM_FIELDS) begin
			case (phase)
				PH_SPACE: begin
					if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR))
						phase = PH_SPACE;
					else if (b == CH_PLUS)
						phase = PH_SIGN;
					else if (b == CH_MINUS) begin
						neg   = 1'b1;
						phase = PH_SIGN;
					end else if (digit) begin
						phase = PH_DIGITS;
						take_digit(int'(b - CH_0));
					end else
						phase = PH_DONE;
				end
				PH_SIGN, PH_DIGITS: begin
					if (digit) begin
						phase = PH_DIGITS;
						take_digit(int'(b - CH_0));
					end else
						phase = PH_DONE;
				end
				default: ;
			endcase
		end
	endtask

	task automatic parse_byte(input logic [7:0] b);
		int         pos;
		int         h;
		logic [1:0] st;
		result_t    r;
		pos = int'(line_len);
		if (b == CH_NL) begin
			if (!comment) begin
				if (pos + 1 <= SHORT_LAST + 1)
					st = ST_SHORT;
				else if (star_hit && csum == rx_csum)
					st = ST_OK;
				else
					st = ST_CSUM;
				if (st == ST_OK)
					held = pend;
				for (int k = 0; k < NUM_OUTV; k++)
					r.vals[k] = held[k];
				r.stop   = (held[NUM_FIELDS - 1] == 16'd1);
				r.status = st;
				line_verdicts.push_back(r);
			end
			clear_line();
		end else if (pos < LINE_LIMIT) begin
			line_len = line_len + 8'd1;
			if (pos == 0 && b == CH_HASH)
				comment = 1'b1;
			if (pos >= 1) begin
				if (!star_hit) begin
					if (b == CH_STAR && pos <= STAR_LAST)
						star_hit = 1'b1;
					else if (pos <= XOR_LAST)
						csum = csum ^ b;
				end else if (!hex_end) begin
					h = hex_digit_value(b);
					if (h >= 0)
						rx_csum = {rx_csum[3:0], h[3:0]};
					else
						hex_end = 1'b1;
				end
			end
			if (b == CH_COMMA) begin
				if (commas < COMMA_MAX)
					commas = commas + 4'd1;
				phase = PH_SPACE;
				neg   = 1'b0;
				mag   = '0;
			end else
				field_char(b);
		end
	endtask

	task automatic check_result();
		result_t want;
		result_t got;
		if (line_verdicts.size() == 0)
			flag($sformatf("result with nothing predicted, status %0d", line_status));
		else begin
			want = line_verdicts.pop_front();
			got.vals[0] = frame_id;
			got.vals[1] = panel_volts_tenths;
			got.vals[2] = battery_volts_tenths;
			got.vals[3] = panel_power;
			got.vals[4] = battery_power;
			got.vals[5] = electronics_power;
			got.vals[6] = left_power;
			got.vals[7] = right_power;
			got.vals[8] = accessory_power;
			got.stop    = stop_pressed;
			got.status  = line_status;
			for (int k = 0; k < NUM_OUTV; k++)
				if (got.vals[k] !== want.vals[k])
					flag($sformatf("value %0d expected %0d actual %0d", k,
						$signed(want.vals[k]), $signed(got.vals[k])));
			if (got.stop !== want.stop)
				flag($sformatf("stop_pressed expected %0b actual %0b", want.stop, got.stop));
			if (got.status !== want.status)
				flag($sformatf("line_status expected %0d actual %0d", want.status,
					got.status));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_line();
			foreach (held[k])
				held[k] = '0;
			line_verdicts.delete();
			fails = 0;
		end else begin
			if (push && !full)
				parse_byte(rx_byte);
			if (pop && !empty)
				check_result();
		end
		outstanding = line_verdicts.size();
	end

endmodule

>>> verif/xor_checked_telemetry_line_parser_unit_tb.sv
// ----------------------------------------------------------------------------
// Telemetry line parser testbench
// Sends directed and random telemetry lines (well-formed sentences, broken
// checksums, comments, short, long and noisy lines) byte by byte with random
// gaps on both sides. The checker beside the block scores every result.
// ----------------------------------------------------------------------------
module xor_checked_telemetry_line_parser_unit_tb;
	import xctlp_pkg::*;

	typedef enum int {SEAL_GOOD, SEAL_BAD, SEAL_NOSTAR} seal_t;

	localparam int CYCLE_LIMIT = 200000;
	localparam int IDLE_PCT    = 24;

	logic               clk;
	logic               arst_n;
	logic               push;
	logic               full;
	logic [7:0]         rx_byte;
	logic               empty;
	logic               pop;
	logic signed [15:0] frame_id;
	logic signed [15:0] panel_volts_tenths;
	logic signed [15:0] battery_volts_tenths;
	logic signed [15:0] panel_power;
	logic signed [15:0] battery_power;
	logic signed [15:0] electronics_power;
	logic signed [15:0] left_power;
	logic signed [15:0] right_power;
	logic signed [15:0] accessory_power;
	logic               stop_pressed;
	logic [1:0]         line_status;
	int                 fails;
	int                 outstanding;

	logic [7:0] stream [$];
	logic [7:0] line_buf [$];
	int         n_sent  = 0;
	int         cyc     = 0;
	logic       running = 1'b0;
	logic       steady;

	// window with no gaps on either side
	assign steady = (cyc >= 300) && (cyc < 700);

	xor_checked_telemetry_line_parser_unit dut (
		.clk                  (clk),
		.arst_n               (arst_n),
		.push                 (push),
		.full                 (full),
		.rx_byte              (rx_byte),
		.empty                (empty),
		.pop                  (pop),
		.frame_id             (frame_id),
		.panel_volts_tenths   (panel_volts_tenths),
		.battery_volts_tenths (battery_volts_tenths),
		.panel_power          (panel_power),
		.battery_power        (battery_power),
		.electronics_power    (electronics_power),
		.left_power           (left_power),
		.right_power          (right_power),
		.accessory_power      (accessory_power),
		.stop_pressed         (stop_pressed),
		.line_status          (line_status)
	);

	xor_checked_telemetry_line_parser_unit_checker chk (
		.clk                  (clk),
		.arst_n               (arst_n),
		.push                 (push),
		.full                 (full),
		.rx_byte              (rx_byte),
		.empty                (empty),
		.pop                  (pop),
		.frame_id             (frame_id),
		.panel_volts_tenths   (panel_volts_tenths),
		.battery_volts_tenths (battery_volts_tenths),
		.panel_power          (panel_power),
		.battery_power        (battery_power),
		.electronics_power    (electronics_power),
		.left_power           (left_power),
		.right_power          (right_power),
		.accessory_power      (accessory_power),
		.stop_pressed         (stop_pressed),
		.line_status          (line_status),
		.fails                (fails),
		.outstanding          (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	task automatic add_byte(input logic [7:0] b);
		line_buf.push_back(b);
	endtask

	task automatic add_str(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endtask

	task automatic add_letters(input int n);
		for (int i = 0; i < n; i++)
			line_buf.push_back(CH_UA + 8'($urandom_range(0, 25)));
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit up);
		if (n < 4'd10)
			return CH_0 + 8'(n);
		return (up ? CH_UA : CH_LA) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] space_char();
		case ($urandom_range(0, 4))
			0: return CH_TAB;
			1: return 8'h0B;
			2: return 8'h0C;
			3: return CH_CR;
			default: return CH_SPACE;
		endcase
	endfunction

	function automatic string pick_tail();
		case ($urandom_range(0, 3))
			0: return "\r";
			1: return " ";
			2: return "\rZ";
			default: return "";
		endcase
	endfunction

	function automatic string rand_field(input bit tenth);
		string s;
		int    mag;
		mag = $urandom_range(0, 9999);
		if (tenth && $urandom_range(0, 2) == 0)
			s = $urandom_range(0, 1) ? "1" : "01";
		else begin
			case ($urandom_range(0, 15))
				0: s = "";
				1: s = "x7";
				2: s = "-";
				3: s = $sformatf("+%0d", mag);
				4: s = $sformatf("-%0d", mag);
				5: s = $sformatf("%c%c%0d", space_char(), space_char(), mag);
				6: s = $sformatf("%0d", $urandom_range(32000, 9999999));
				7: s = $sformatf("-%0d", $urandom_range(32000, 9999999));
				8: begin
					case ($urandom_range(0, 3))
						0: s = "32767";
						1: s = "32768";
						2: s = "-32768";
						default: s = "-32769";
					endcase
				end
				9: s = $sformatf("%0d.%0d", $urandom_range(0, 300), $urandom_range(0, 9));
				10: s = $urandom_range(0, 1) ? "+ 5" : $sformatf("%0d-%0d", mag, mag);
				default: s = $sformatf("%0d", mag);
			endcase
		end
		return s;
	endfunction

	task automatic rand_sentence(input int name_len, input int nfields);
		add_str("$");
		add_letters(name_len);
		for (int i = 0; i < nfields; i++) begin
			add_byte(CH_COMMA);
			add_str(rand_field(i == NUM_FIELDS - 1));
		end
	endtask

	// close the line in line_buf: optional star and hex check, tail, newline
	task automatic seal(input seal_t how, input string tail);
		logic [7:0] sum;
		bit         up;
		int         style;
		sum = '0;
		for (int i = 1; i < line_buf.size(); i++)
			sum = sum ^ line_buf[i];
		if (how == SEAL_BAD)
			sum = sum ^ 8'($urandom_range(1, 255));
		if (how != SEAL_NOSTAR) begin
			up    = $urandom_range(0, 1);
			style = $urandom_range(0, 3);
			add_byte(CH_STAR);
			if (style == 0)
				add_byte(CH_0);
			if (style != 1 || sum[7:4] != 4'd0)
				add_byte(hex_char(sum[7:4], up));
			add_byte(hex_char(sum[3:0], up));
		end
		add_str(tail);
		add_byte(CH_NL);
		foreach (line_buf[i])
			stream.push_back(line_buf[i]);
		line_buf.delete();
	endtask

	// byte sender
	always @(posedge clk) begin : send_bytes
		int nxt;
		nxt = n_sent + ((push && !full) ? 1 : 0);
		if (running && !(push && full)) begin
			if (nxt < stream.size() && (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				push    <= 1'b1;
				rx_byte <= stream[nxt];
			end else begin
				push    <= 1'b0;
				rx_byte <= 8'($urandom);
			end
		end
		n_sent <= nxt;
	end

	// result receiver
	always @(posedge clk)
		if (running)
			pop <= steady || ($urandom_range(0, 99) >= IDLE_PCT);

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		string      zz;
		int         pick;
		int         n_lines;
		logic [7:0] b;
		push    = 1'b0;
		pop     = 1'b0;
		rx_byte = 8'h00;
		arst_n  = 1'b0;

		// short lines: lone newline, four bytes with newline
		seal(SEAL_NOSTAR, "");
		add_str("$AB");
		seal(SEAL_NOSTAR, "");
		// five bytes, no star
		add_str("$ABC");
		seal(SEAL_NOSTAR, "");
		// field extremes and saturation, stop pressed
		add_str("$TLM,32767,-32768,99999,-99999,0, +12,-0,,abc,1");
		seal(SEAL_GOOD, "\r");
		add_str("#TLM,1,2,3");
		seal(SEAL_GOOD, "");
		add_str("$TLM,7,8,9");
		seal(SEAL_GOOD, "");
		add_str("$TLM,1,1,1,1,1,1,1,1,1,1");
		seal(SEAL_BAD, "");
		// star with no hex digits, check of zero
		add_str("$AA");
		seal(SEAL_NOSTAR, "*");
		// star on the last recognized position, then one past it
		add_str("$");
		add_letters(STAR_LAST - 1);
		seal(SEAL_GOOD, "");
		add_str("$");
		add_letters(STAR_LAST);
		seal(SEAL_GOOD, "");
		// line cut at the limit, newline still ends it
		zz = "";
		for (int i = 0; i < 150; i++)
			zz = {zz, "Z"};
		add_str("$TLM,5,6");
		seal(SEAL_GOOD, zz);
		add_str("$A");
		add_byte(8'h00);
		add_str(",42,-7");
		seal(SEAL_GOOD, "");
		add_str("$TLM,1,2,3,4,5,6,7,8,9,01,11,12,13");
		seal(SEAL_GOOD, "");
		add_str("$#X,3");
		seal(SEAL_GOOD, "");
		add_str("$T,+-3,1-2,+ 5,\t-17,0x1F");
		seal(SEAL_GOOD, "");
		// burst of short lines to back up the result queue
		for (int i = 0; i < 20; i++)
			seal(SEAL_NOSTAR, "");
		add_str("#");
		seal(SEAL_NOSTAR, "");

		n_lines = 0;
		while (stream.size() < 800 || n_lines < 3) begin
			pick = $urandom_range(0, 99);
			if (pick < 62) begin
				rand_sentence($urandom_range(1, 5), $urandom_range(0, 12));
				seal(SEAL_GOOD, pick_tail());
			end else if (pick < 70) begin
				rand_sentence($urandom_range(1, 5), $urandom_range(0, 12));
				seal(SEAL_BAD, pick_tail());
			end else if (pick < 74) begin
				rand_sentence($urandom_range(1, 5), $urandom_range(0, 12));
				seal(SEAL_NOSTAR, pick_tail());
			end else if (pick < 78) begin
				add_str("#");
				rand_sentence($urandom_range(0, 5), $urandom_range(0, 10));
				seal(SEAL_GOOD, "");
			end else if (pick < 83) begin
				for (int i = $urandom_range(0, 3); i > 0; i--) begin
					b = 8'($urandom);
					add_byte((b == CH_NL) ? 8'h00 : b);
				end
				seal(SEAL_NOSTAR, "");
			end else if (pick < 90) begin
				for (int i = $urandom_range(1, 40); i > 0; i--)
					add_byte(8'($urandom));
				seal($urandom_range(0, 1) ? SEAL_GOOD : SEAL_NOSTAR, "");
			end else if (pick < 95) begin
				// star lands around the end of the checksum span
				rand_sentence($urandom_range(STAR_LAST - 7, STAR_LAST + 2), 0);
				seal(SEAL_GOOD, "");
			end else begin
				zz = "";
				for (int i = $urandom_range(100, 160); i > 0; i--)
					zz = {zz, "Q"};
				rand_sentence($urandom_range(1, 5), $urandom_range(5, 10));
				seal(SEAL_GOOD, zz);
			end
			n_lines++;
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n  = 1'b1;
		running = 1'b1;

		while (n_sent < stream.size())
			@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (fails == 0 && outstanding == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
